// ----- sv/opa_pkg.sv -----
package opa_pkg;

   localparam int AddrW = 27;
   localparam logic [AddrW-1:0] MinPool = 27'd16384;
   localparam logic [AddrW-1:0] HeaderBytes = 27'd8;

   localparam logic [1:0] CsrEnable = 2'd0;
   localparam logic [1:0] CsrScreen = 2'd1;
   localparam logic [1:0] CsrMap    = 2'd2;
   localparam logic [1:0] CsrAlign  = 2'd3;

   localparam logic [1:0] StOk       = 2'd0;
   localparam logic [1:0] StNoMem    = 2'd1;
   localparam logic [1:0] StUnknown  = 2'd2;
   localparam logic [1:0] StDisabled = 2'd3;

   localparam logic ModeAlloc = 1'b0;
   localparam logic ModeFree  = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [AddrW-1:0] amount;
      logic [AddrW-1:0] region_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [AddrW-1:0] granted_offset;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_FREE_PREV,
      ST_SHIFT_DN_RD,
      ST_SHIFT_DN_WR,
      ST_GAP_RD,
      ST_GAP_CHK,
      ST_GROW,
      ST_SHIFT_UP_RD,
      ST_SHIFT_UP_WR,
      ST_INSERT,
      ST_RESP
   } state_type;

endpackage

// ----- sv/opa_ram.sv -----
module opa_ram #(
   parameter int WIDTH = 54,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/offscreen_pool_allocator_unit.sv -----
// Channel  | Direction | Ports                      | Transaction
// req      | in        | req_valid/req_stall/req    | one allocate or free request
// rsp      | out       | rsp_valid/rsp_stall/rsp    | one status + granted offset
// csr      | in        | csr_we/csr_index/csr_wdata | register write, no wait
// One request at a time; region table in one single-port-read RAM (start,end).
// Free: entries are read and checked in turn up to the match, then each later one
// moves down a place. Allocate: gaps are examined in turn, else the pool grows
// down; then entries move up. The read-then-write RAM loop sets the worst case.
// Reset is synchronous; the table is empty (count zero), RAM is not cleared.
// req_stall is high whenever a request is in progress or its result is held;
// a stalled result holds its value until taken.
module offscreen_pool_allocator_unit #(
   parameter int MAX_REGIONS = 64,
   parameter int ENTRY_BYTES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  opa_pkg::req_type       req,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output opa_pkg::rsp_type       rsp,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [26:0]            csr_wdata
);
   import opa_pkg::*;

   localparam int IW = $clog2(MAX_REGIONS);
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int MW = 2 * AddrW;
   localparam logic [CW-1:0] MaxCnt = CW'(MAX_REGIONS);
   localparam logic [AddrW-1:0] EntryB = AddrW'(ENTRY_BYTES);

   // configuration
   logic             enable_ff;
   logic [AddrW-1:0] screen_ff, map_ff;
   logic [3:0]       align_ff;

   // control state
   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AddrW-1:0] lowest_ff, lowest_in;
   logic [CW-1:0]    idx_ff, idx_in;     // scan / move pointer
   logic [CW-1:0]    pos_ff, pos_in;     // free or insert position
   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic [AddrW-1:0] ns_ff, ns_in;       // new region start
   logic [AddrW-1:0] ne_ff, ne_in;       // new region end

   // memory
   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [MW-1:0] wr_data, rd_data;
   logic [AddrW-1:0] rd_start, rd_end;

   opa_ram #(.WIDTH(MW), .DEPTH(MAX_REGIONS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_start = rd_data[MW-1:AddrW];
   assign rd_end   = rd_data[AddrW-1:0];

   logic [AddrW-1:0] amask, nl;
   logic [AddrW:0]   fs_sum, fs_al, te_sum;   // one bit of headroom
   logic             usable;

   always_comb begin
      amask   = ~((AddrW'(1) << align_ff) - AddrW'(1));
      // gap start = end of the entry just read, aligned up
      fs_sum  = {1'b0, rd_end} + {1'b0, ~amask};
      fs_al   = fs_sum & {1'b1, amask};
      nl      = (lowest_ff - req_ff.amount) & amask;
      te_sum  = {1'b0, screen_ff} + {1'b0, HeaderBytes}
                + (AddrW+1)'(AddrW'(count_ff) * EntryB);
      usable  = enable_ff && ({1'b0, map_ff} >= ({1'b0, screen_ff} + {1'b0, MinPool}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         screen_ff <= '0;
         map_ff    <= '0;
         align_ff  <= 4'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrEnable: enable_ff <= csr_wdata[0];
            CsrScreen: screen_ff <= csr_wdata;
            CsrMap:    map_ff    <= csr_wdata;
            CsrAlign:  align_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lowest_in = lowest_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      rsp_in   = rsp_ff;
      ns_in    = ns_ff;
      ne_in    = ne_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[IW-1:0];
      wr_data  = rd_data;
      rd_addr  = idx_ff[IW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in = '0;
               if (req.mode == ModeFree) begin
                  state_in = ST_FREE_RD;
               end else if (!usable) begin
                  rsp_in = '{status: StDisabled, granted_offset: '0};
                  state_in = ST_RESP;
               end else if (count_ff == MaxCnt) begin
                  rsp_in = '{status: StNoMem, granted_offset: '0};
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_GAP_RD;
               end
            end
         end
         ST_FREE_RD: begin
            if (idx_ff >= count_ff) begin
               rsp_in = '{status: StUnknown, granted_offset: '0};
               state_in = ST_RESP;
            end else begin
               state_in = ST_FREE_CHK;
            end
         end
         ST_FREE_CHK: begin
            if (rd_start == req_ff.region_offset) begin
               pos_in = idx_ff;
               if (rd_start <= lowest_ff) begin
                  if (idx_ff == '0) begin
                     lowest_in = map_ff;
                     idx_in = idx_ff + CW'(1);
                     state_in = ST_SHIFT_DN_RD;
                  end else begin
                     rd_addr = IW'(idx_ff - CW'(1));
                     state_in = ST_FREE_PREV;
                  end
               end else begin
                  idx_in = idx_ff + CW'(1);
                  state_in = ST_SHIFT_DN_RD;
               end
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_FREE_RD;
            end
         end
         ST_FREE_PREV: begin
            lowest_in = rd_start;
            idx_in = idx_ff + CW'(1);
            state_in = ST_SHIFT_DN_RD;
         end
         ST_SHIFT_DN_RD: begin
            // idx points at the entry to pull down one place
            if (idx_ff >= count_ff) begin
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) lowest_in = map_ff;
               rsp_in = '{status: StOk, granted_offset: '0};
               state_in = ST_RESP;
            end else begin
               state_in = ST_SHIFT_DN_WR;
            end
         end
         ST_SHIFT_DN_WR: begin
            wr_en = 1'b1;
            wr_addr = IW'(idx_ff - CW'(1));
            wr_data = rd_data;
            idx_in = idx_ff + CW'(1);
            state_in = ST_SHIFT_DN_RD;
         end
         ST_GAP_RD: begin
            // read entry idx; gap between idx (its end) and idx-1 (held start)
            if (idx_ff >= count_ff) begin
               state_in = ST_GROW;
            end else begin
               state_in = ST_GAP_CHK;
            end
         end
         ST_GAP_CHK: begin
            // rd = entry idx; ns holds the start of entry idx-1 (gap end)
            idx_in = idx_ff + CW'(1);
            ns_in = rd_start;
            state_in = ST_GAP_RD;
            if (idx_ff != '0 && rd_end != ns_ff) begin
               if ({1'b0, ns_ff} > fs_al &&
                   ({1'b0, ns_ff} - fs_al) > {1'b0, req_ff.amount}) begin
                  ne_in = fs_al[AddrW-1:0] + req_ff.amount;
                  ns_in = fs_al[AddrW-1:0];
                  pos_in = idx_ff;
                  idx_in = count_ff;
                  state_in = ST_SHIFT_UP_RD;
               end
            end
         end
         ST_GROW: begin
            if (req_ff.amount > lowest_ff || te_sum >= {1'b0, nl}) begin
               rsp_in = '{status: StNoMem, granted_offset: '0};
               state_in = ST_RESP;
            end else begin
               ns_in = nl;
               ne_in = lowest_ff;
               lowest_in = nl;
               pos_in = count_ff;
               idx_in = count_ff;
               state_in = ST_SHIFT_UP_RD;
            end
         end
         ST_SHIFT_UP_RD: begin
            // move entry idx-1 to idx while idx > pos
            if (idx_ff == pos_ff) begin
               state_in = ST_INSERT;
            end else begin
               rd_addr = IW'(idx_ff - CW'(1));
               state_in = ST_SHIFT_UP_WR;
            end
         end
         ST_SHIFT_UP_WR: begin
            wr_en = 1'b1;
            wr_addr = idx_ff[IW-1:0];
            wr_data = rd_data;
            idx_in = idx_ff - CW'(1);
            state_in = ST_SHIFT_UP_RD;
         end
         ST_INSERT: begin
            wr_en = 1'b1;
            wr_addr = pos_ff[IW-1:0];
            wr_data = {ns_ff, ne_ff};
            count_in = count_ff + CW'(1);
            rsp_in = '{status: StOk, granted_offset: ns_ff};
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_we && csr_index == CsrMap) begin
         count_in = '0;
         lowest_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         lowest_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         lowest_ff <= lowest_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      rsp_ff  <= rsp_in;
      ns_ff   <= ns_in;
      ne_ff   <= ne_in;
      if (state_ff == ST_IDLE && req_valid) req_ff <= req;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp       = rsp_ff;
endmodule

// ----- sv/opa_checker.sv -----
module opa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input opa_pkg::rsp_type rsp
);
   import opa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("result changed while stalled");

   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != StOk |-> rsp.granted_offset == '0)
      else $error("offset on failed transaction");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("no busy after accept");
endmodule

bind offscreen_pool_allocator_unit opa_checker u_opa_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);

// ----- verif/offscreen_pool_allocator_unit_test.sv -----
module offscreen_pool_allocator_unit_test;
   import opa_pkg::*;

   localparam int NumRegions = 64;
   localparam int EntrySize = 8;
   // settle time before csr writes
   localparam int SettleCycles = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CsrEnable;
   logic [26:0] csr_wdata = '0;

   offscreen_pool_allocator_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------
   // Shadow of the allocator: registers plus region table
   // ---------------------------------------------------------------
   logic        pool_en;
   logic [26:0] screen_sz;
   logic [26:0] map_sz;
   logic [3:0]  align_sh;
   int          live_count;
   logic [26:0] low_mark;
   logic [26:0] tbl_start [NumRegions];
   logic [26:0] tbl_end   [NumRegions];

   req_type pending_reqs [$];   // transactions waiting for the driver
   rsp_type grants_due   [$];   // predicted results, oldest first

   int errors = 0;
   int n_accepted = 0;
   int n_checked = 0;
   int n_granted = 0;
   int n_freed = 0;
   int n_nomem = 0;
   bit idle_on = 1'b1;          // random gaps/stalls allowed
   int gap_left = 0;
   int stall_left = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   function automatic void table_insert(int pos, longint unsigned s, longint unsigned e);
      int k;
      for (k = live_count; k > pos; k--) begin
         tbl_start[k] = tbl_start[k-1];
         tbl_end[k]   = tbl_end[k-1];
      end
      tbl_start[pos] = s[26:0];
      tbl_end[pos]   = e[26:0];
      live_count++;
   endfunction

   function automatic void table_remove(int pos);
      int k;
      if (tbl_start[pos] <= low_mark)
         low_mark = (pos > 0) ? tbl_start[pos-1] : map_sz;
      live_count--;
      for (k = pos; k < live_count; k++) begin
         tbl_start[k] = tbl_start[k+1];
         tbl_end[k]   = tbl_end[k+1];
      end
      if (live_count == 0) low_mark = map_sz;
   endfunction

   // Works out the result of one request and updates the shadow table.
   function automatic rsp_type predict_grant(req_type r);
      longint unsigned al, fs, fe, tend, nl;
      int i;
      rsp_type o;
      o.status = StOk;
      o.granted_offset = '0;
      al = 64'd1 << align_sh;
      if (r.mode == ModeFree) begin
         for (i = 0; i < live_count; i++) begin
            if (tbl_start[i] == r.region_offset) begin
               table_remove(i);
               return o;
            end
         end
         o.status = StUnknown;
         return o;
      end
      if (!pool_en || longint'(map_sz) < longint'(screen_sz) + 16384) begin
         o.status = StDisabled;
         return o;
      end
      if (live_count >= NumRegions) begin
         o.status = StNoMem;
         return o;
      end
      // first fit between neighbours
      for (i = 0; i + 1 < live_count; i++) begin
         fs = tbl_end[i+1];
         fe = tbl_start[i];
         if (fs != fe) begin
            fs = (fs + al - 1) & ~(al - 1);
            if (fe > fs && fe - fs > r.amount) begin
               table_insert(i + 1, fs, fs + r.amount);
               o.granted_offset = fs[26:0];
               return o;
            end
         end
      end
      // grow downward below the lowest region
      tend = longint'(screen_sz) + 8 + longint'(live_count) * EntrySize;
      if (r.amount > low_mark) begin
         o.status = StNoMem;
         return o;
      end
      nl = (longint'(low_mark) - r.amount) & ~(al - 1);
      if (tend >= nl) begin
         o.status = StNoMem;
         return o;
      end
      table_insert(live_count, nl, low_mark);
      low_mark = nl[26:0];
      o.granted_offset = nl[26:0];
      return o;
   endfunction

   function automatic void note_error(string what);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $realtime, what);
   endfunction

   // ---------------------------------------------------------------
   // Clock and watchdog
   // ---------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("Timeout: %0d results still outstanding", grants_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------
   // Driver: request channel. Prediction happens at acceptance.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type p;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            p = predict_grant(req);
            if (req.mode == ModeFree && p.status == StOk) n_freed++;
            grants_due.push_back(p);
            n_accepted++;
         end
         // payload only moves when nothing is held
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               req <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               gap_left = idle_on ? pick_gap() : 0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: result channel, field by field against oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (grants_due.size() == 0) begin
               note_error($sformatf("unexpected result status=%0d offset=%0h",
                                    rsp.status, rsp.granted_offset));
            end else begin
               want = grants_due.pop_front();
               n_checked++;
               if (rsp.status !== want.status)
                  note_error($sformatf("status exp %0d got %0d", want.status, rsp.status));
               if (rsp.granted_offset !== want.granted_offset)
                  note_error($sformatf("granted_offset exp %0h got %0h",
                                       want.granted_offset, rsp.granted_offset));
               if (want.status == StOk && want.granted_offset != 0) n_granted++;
               if (want.status == StNoMem) n_nomem++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(3) == 0) begin
            stall_left = pick_gap();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic push_req(logic mode, logic [26:0] amt, logic [26:0] off);
      req_type r;
      r.mode = mode;
      r.amount = amt;
      r.region_offset = off;
      pending_reqs.push_back(r);
   endtask

   // every transaction taken and answered, then let the block settle
   task automatic wait_quiet();
      while (pending_reqs.size() != 0 || req_valid || grants_due.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [26:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CsrEnable: pool_en = val[0];
         CsrScreen: screen_sz = val;
         CsrMap: begin
            map_sz = val;
            live_count = 0;
            low_mark = val;
         end
         default: align_sh = val[3:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_pool(logic en, logic [26:0] scr, logic [26:0] map, logic [3:0] sh);
      wait_quiet();
      write_csr(CsrScreen, scr);
      write_csr(CsrMap, map);
      write_csr(CsrAlign, {23'd0, sh});
      write_csr(CsrEnable, {26'd0, en});
   endtask

   // Mostly well-formed traffic: allocations and frees of live regions,
   // with stale/random frees and oversize allocations mixed in.
   task automatic random_traffic(int n, int amt_max);
      int r, k;
      logic [26:0] amt, off;
      for (k = 0; k < n; k++) begin
         while (pending_reqs.size() >= 2) @(posedge clock);
         r = $urandom_range(99);
         amt = 27'($urandom);
         off = 27'($urandom);
         if (r < 42 && live_count > 0) begin
            off = tbl_start[$urandom_range(live_count - 1)];
            push_req(ModeFree, amt, off);
         end else if (r < 50) begin
            push_req(ModeFree, amt, off);
         end else begin
            r = $urandom_range(99);
            if (r < 85) amt = 27'($urandom_range(amt_max));
            else if (r < 90) amt = '0;
            push_req(ModeAlloc, amt, off);
         end
      end
   endtask

   initial begin
      pool_en = 1'b0;
      screen_sz = '0;
      map_sz = '0;
      align_sh = 4'd3;
      live_count = 0;
      low_mark = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // out of reset: disabled, empty table
      push_req(ModeAlloc, 27'd0, 27'd0);
      push_req(ModeAlloc, 27'h7FF_FFFF, 27'h7FF_FFFF);
      push_req(ModeFree, 27'h7FF_FFFF, 27'd0);
      push_req(ModeFree, 27'd0, 27'h7FF_FFFF);

      // small pool, directed: grow, gap reuse, middle free, unknown free, too large
      set_pool(1'b1, 27'd8192, 27'd65536, 4'd3);
      push_req(ModeAlloc, 27'd100, 27'd0);        // 65432
      push_req(ModeAlloc, 27'd0, 27'd0);          // zero size at the mark
      push_req(ModeAlloc, 27'd1000, 27'd0);
      push_req(ModeAlloc, 27'd500, 27'd0);
      push_req(ModeFree, 27'd0, 27'd65432 - 27'd1000 & ~27'd7); // middle
      push_req(ModeAlloc, 27'd300, 27'd0);        // lands in the hole
      push_req(ModeFree, 27'd0, 27'd12345);       // unknown offset
      push_req(ModeAlloc, 27'd70000, 27'd0);      // larger than the mark
      push_req(ModeAlloc, 27'd57000, 27'd0);      // runs into the table area
      push_req(ModeAlloc, 27'd7, 27'd0);
      idle_on = 1'b0;                             // a stretch without gaps
      random_traffic(120, 2000);
      idle_on = 1'b1;
      random_traffic(100, 2000);

      // hold off until every result is back, then no-stall burst again
      wait_quiet();
      idle_on = 1'b0;
      random_traffic(60, 400);
      idle_on = 1'b1;

      set_pool(1'b1, 27'd0, 27'd67108864, 4'd12);
      random_traffic(250, 100000);
      set_pool(1'b1, 27'd4096, 27'd32768, 4'd0);
      random_traffic(200, 1500);
      set_pool(1'b1, 27'd1024, 27'd200000, 4'd15);
      random_traffic(150, 20000);
      // switch off without a map write: frees still work, allocs refused
      wait_quiet();
      write_csr(CsrEnable, 27'd0);
      random_traffic(60, 2000);
      set_pool(1'b1, 27'd100000, 27'd110000, 4'd5);   // pool too small
      random_traffic(60, 2000);
      set_pool(1'b1, 27'h7FF_FFFF, 27'd0, 4'd9);
      random_traffic(40, 2000);
      set_pool(1'b1, 27'd16, 27'd67108864, 4'd1);
      random_traffic(200, 3000000);
      set_pool(1'b1, 27'd2048, 27'd100000, 4'd13);
      random_traffic(200, 8000);

      wait_quiet();
      $display("Covered %0d transactions over several pool settings: %0d grants, %0d frees,",
               n_accepted, n_granted, n_freed);
      $display("%0d out-of-memory answers; %0d results checked.", n_nomem, n_checked);
      if (grants_due.size() != 0)
         note_error($sformatf("%0d results never arrived", grants_due.size()));
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches in total", errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
